FILE: hdl/teq_pkg.sv
// Shared types, codes and constants for the timed event queue.
// No dependencies; imported by teq_cell and timed_event_queue_unit.
package teq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int TIME_W       = 32;
    localparam int ID_W         = 16;
    localparam int MAX_FIRE     = 16;
    localparam int FIRE_W       = $clog2(MAX_FIRE + 1);
    localparam int RM_W         = 5;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [RM_W-1:0]   RM_MAX   = '1;

    // input modes
    localparam logic [1:0] MODE_SCHEDULE = 2'd0;
    localparam logic [1:0] MODE_TICK     = 2'd1;
    localparam logic [1:0] MODE_CANCEL   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_FIRED     = 3'd0;
    localparam logic [2:0] ST_NOTHING   = 3'd1;
    localparam logic [2:0] ST_SCHEDULED = 3'd2;
    localparam logic [2:0] ST_DROPPED   = 3'd3;
    localparam logic [2:0] ST_CANCELLED = 3'd4;

    // cell operations
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_SHIFT  = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] due;
        logic [ID_W-1:0]   recv;
        logic [ID_W-1:0]   hand;
    } entry_t;

    typedef struct packed {
        logic [1:0] op;
        logic       wrap;   // on shift, the tail cell takes the head entry
    } cell_cmd_t;

endpackage

FILE: hdl/teq_cell.sv
// One slot of the sorted event row: holds an entry, inserts, or shifts left.
// Depends on teq_pkg.
module teq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic               clk,
    input  teq_pkg::cell_cmd_t cmd,
    input  logic [CW-1:0]      count,
    input  teq_pkg::entry_t    new_e,
    input  teq_pkg::entry_t    prev_e,
    input  teq_pkg::entry_t    next_e,
    input  teq_pkg::entry_t    head_e,
    input  logic               keep_prev,
    output teq_pkg::entry_t    cur,
    output logic               keep
);
    import teq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // an occupied slot stays put on insert when its due time is not later
    assign keep = (count > CW'(IDX)) && (entry_reg.due <= new_e.due);
    assign cur  = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (!keep)
                begin
                    entry_next = keep_prev ? new_e : prev_e;
                end
            end
            CELL_SHIFT:
            begin
                if (cmd.wrap && (count == CW'(IDX + 1)))
                begin
                    entry_next = head_e;
                end
                else
                begin
                    entry_next = next_e;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: hdl/timed_event_queue_unit.sv
// Timed event queue: a row of teq_cell slots kept sorted by due time, plus control.
// Depends on teq_pkg and teq_cell.
// Schedule: registered result in the next cycle; next beat taken then unless stalled.
// Tick: up to MAX_FIRE due entries, one per cycle unless stalled (else nothing-due).
// Cancel: walks the queue through slot 0, one entry per cycle, then gives its result.
// Reset clears the entry count, control and output valid; slot contents stay undefined.
module timed_event_queue_unit #(
    parameter int CAPACITY = teq_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  mode,
    input  logic [teq_pkg::TIME_W-1:0]  now_time,
    input  logic [teq_pkg::ID_W-1:0]    receiver_id,
    input  logic [teq_pkg::ID_W-1:0]    handler_id,
    input  logic [teq_pkg::TIME_W-1:0]  delay,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  status,
    output logic [teq_pkg::ID_W-1:0]    fired_receiver,
    output logic [teq_pkg::ID_W-1:0]    fired_handler,
    output logic [teq_pkg::RM_W-1:0]    removed_count,
    output logic                        last
);
    import teq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_TICK   = 2'd1;
    localparam logic [1:0] S_CANCEL = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     steps_reg, steps_next;
    logic [FIRE_W-1:0] fire_reg, fire_next;
    logic [RM_W-1:0]   removed_reg, removed_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [ID_W-1:0]   recv_reg, recv_next;

    logic              out_valid_reg, out_valid_next;
    logic [2:0]        status_reg, status_next;
    logic [ID_W-1:0]   frecv_reg, frecv_next;
    logic [ID_W-1:0]   fhand_reg, fhand_next;
    logic [RM_W-1:0]   rmcnt_reg, rmcnt_next;
    logic              last_reg, last_next;

    logic              out_free;
    logic              accept;
    logic [TIME_W:0]   due_sum;
    entry_t            new_e;
    cell_cmd_t         cmd;
    logic              head_due;
    logic              more_due;
    logic              drop;

    entry_t            cell_q [CAPACITY];
    entry_t            prev_q [CAPACITY];
    entry_t            next_q [CAPACITY];
    logic [CAPACITY-1:0] keep_vec;
    logic [CAPACITY-1:0] keep_prev_vec;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;

    // saturate the due time at the top of the range
    assign due_sum   = {1'b0, now_time} + {1'b0, delay};
    assign new_e.due  = due_sum[TIME_W] ? TIME_MAX : due_sum[TIME_W-1:0];
    assign new_e.recv = receiver_id;
    assign new_e.hand = handler_id;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign prev_q[gi]        = cell_q[gi];
                assign keep_prev_vec[gi] = 1'b1;
            end
            else
            begin : g_mid
                assign prev_q[gi]        = cell_q[gi-1];
                assign keep_prev_vec[gi] = keep_vec[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_q[gi] = cell_q[0];
            end
            else
            begin : g_inner
                assign next_q[gi] = cell_q[gi+1];
            end

            teq_cell #(
                .IDX (gi),
                .CW  (CW)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .count     (count_reg),
                .new_e     (new_e),
                .prev_e    (prev_q[gi]),
                .next_e    (next_q[gi]),
                .head_e    (cell_q[0]),
                .keep_prev (keep_prev_vec[gi]),
                .cur       (cell_q[gi]),
                .keep      (keep_vec[gi])
            );
        end
    endgenerate

    assign head_due = (count_reg != '0) && (cell_q[0].due <= now_reg)
                      && (fire_reg < FIRE_W'(MAX_FIRE));
    assign more_due = (count_reg > CW'(1)) && (cell_q[1].due <= now_reg)
                      && (fire_reg < FIRE_W'(MAX_FIRE - 1));
    assign drop     = (cell_q[0].recv == recv_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        steps_next     = steps_reg;
        fire_next      = fire_reg;
        removed_next   = removed_reg;
        now_next       = now_reg;
        recv_next      = recv_reg;
        cmd.op         = CELL_HOLD;
        cmd.wrap       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        frecv_next     = frecv_reg;
        fhand_next     = fhand_reg;
        rmcnt_next     = rmcnt_reg;
        last_next      = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    now_next  = now_time;
                    recv_next = receiver_id;
                    case (mode)
                        MODE_SCHEDULE:
                        begin
                            out_valid_next = 1'b1;
                            frecv_next     = '0;
                            fhand_next     = '0;
                            rmcnt_next     = '0;
                            last_next      = 1'b1;
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                status_next = ST_DROPPED;
                            end
                            else
                            begin
                                status_next = ST_SCHEDULED;
                                cmd.op      = CELL_INSERT;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        MODE_TICK:
                        begin
                            fire_next  = '0;
                            state_next = S_TICK;
                        end
                        MODE_CANCEL:
                        begin
                            steps_next   = count_reg;
                            removed_next = '0;
                            state_next   = S_CANCEL;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_TICK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    rmcnt_next     = '0;
                    if (head_due)
                    begin
                        // pop the head and advance the row
                        status_next = ST_FIRED;
                        frecv_next  = cell_q[0].recv;
                        fhand_next  = cell_q[0].hand;
                        last_next   = !more_due;
                        cmd.op      = CELL_SHIFT;
                        count_next  = count_reg - 1'b1;
                        fire_next   = fire_reg + 1'b1;
                        if (!more_due)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        status_next = ST_NOTHING;
                        frecv_next  = '0;
                        fhand_next  = '0;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_CANCEL:
            begin
                if (steps_reg != '0)
                begin
                    // rotate the head to the tail, or drop it on a match
                    cmd.op     = CELL_SHIFT;
                    cmd.wrap   = !drop;
                    steps_next = steps_reg - 1'b1;
                    if (drop)
                    begin
                        count_next = count_reg - 1'b1;
                        if (removed_reg != RM_MAX)
                        begin
                            removed_next = removed_reg + 1'b1;
                        end
                    end
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_CANCELLED;
                    frecv_next     = '0;
                    fhand_next     = '0;
                    rmcnt_next     = removed_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steps_reg   <= steps_next;
        fire_reg    <= fire_next;
        removed_reg <= removed_next;
        now_reg     <= now_next;
        recv_reg    <= recv_next;
        status_reg  <= status_next;
        frecv_reg   <= frecv_next;
        fhand_reg   <= fhand_next;
        rmcnt_reg   <= rmcnt_next;
        last_reg    <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign fired_receiver = frecv_reg;
    assign fired_handler  = fhand_reg;
    assign removed_count  = rmcnt_reg;
    assign last           = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_sched_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode == MODE_SCHEDULE) && (count_reg < CW'(CAPACITY)))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("schedule did not add an entry");

    a_cancel_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CANCEL) |-> (steps_reg <= count_reg))
        else $error("cancel walk longer than queue");

    // a non-final fired beat is only ever on the port while the tick walk is running
    a_tick_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_FIRED) && !last_reg && !out_stall)
        |-> (state_reg == S_TICK))
        else $error("tick ended before its last beat");

endmodule

FILE: bench/timed_event_queue_unit_tb.sv
// Self-checking bench for timed_event_queue_unit: directed and random schedule/tick/cancel
// traffic with random idling on both channels, checked against an in-bench queue model.
// Depends on teq_pkg and the timed_event_queue_unit RTL.
`timescale 1ns / 1ps

module timed_event_queue_unit_tb;

    import teq_pkg::*;

    localparam int          CAPACITY     = CAPACITY_DEF;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam int          RANDOM_ITEMS = 232;
    localparam int          TAIL_CYCLES  = 40;
    localparam int          CYCLE_LIMIT  = 800_000;

    typedef struct packed {
        logic [1:0]        mode;
        logic [TIME_W-1:0] now;
        logic [ID_W-1:0]   recv;
        logic [ID_W-1:0]   hand;
        logic [TIME_W-1:0] dly;
    } timer_request_t;

    typedef struct packed {
        logic [2:0]      status;
        logic [ID_W-1:0] recv;
        logic [ID_W-1:0] hand;
        logic [RM_W-1:0] removed;
        logic            last;
    } queue_result_t;

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              in_valid       = 1'b0;
    logic              in_stall;
    logic [1:0]        mode           = '0;
    logic [TIME_W-1:0] now_time       = '0;
    logic [ID_W-1:0]   receiver_id    = '0;
    logic [ID_W-1:0]   handler_id     = '0;
    logic [TIME_W-1:0] delay          = '0;
    logic              out_valid;
    logic              out_stall      = 1'b0;
    logic [2:0]        status;
    logic [ID_W-1:0]   fired_receiver;
    logic [ID_W-1:0]   fired_handler;
    logic [RM_W-1:0]   removed_count;
    logic              last;

    timer_request_t queued_requests[$];
    queue_result_t  awaited_results[$];
    timer_request_t next_request;

    // timer queue model: slots kept sorted by due time
    logic [TIME_W-1:0] model_due[CAPACITY];
    logic [ID_W-1:0]   model_recv[CAPACITY];
    logic [ID_W-1:0]   model_hand[CAPACITY];
    int                model_count = 0;

    int   total_requests    = 0;
    int   accepted_requests = 0;
    int   mismatches        = 0;
    int   cycle_count       = 0;
    int   send_gap          = 0;
    int   send_calm         = 0;
    int   stall_left        = 0;
    int   stall_calm        = 0;
    logic request_taken     = 1'b0;

    timed_event_queue_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .now_time       (now_time),
        .receiver_id    (receiver_id),
        .handler_id     (handler_id),
        .delay          (delay),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .fired_receiver (fired_receiver),
        .fired_handler  (fired_handler),
        .removed_count  (removed_count),
        .last           (last)
    );

    always #4 clk = ~clk;

    // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
    function automatic int draw_idle(inout int calm_left);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if (roll < 3) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic advance_timer_model(input logic [1:0] op, input logic [TIME_W-1:0] at,
                                       input logic [ID_W-1:0] who, input logic [ID_W-1:0] hnd,
                                       input logic [TIME_W-1:0] dly);
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] due;
        int                pos;
        int                fire_n;
        int                kept;
        int                gone;
        queue_result_t     res;
        res = '0;
        case (op)
            MODE_SCHEDULE: begin
                if (model_count >= CAPACITY) begin
                    res.status = ST_DROPPED;
                end else begin
                    sum = {1'b0, at} + {1'b0, dly};
                    due = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                    // equal due times: new entry goes behind the existing ones
                    pos = 0;
                    while (pos < model_count && model_due[pos] <= due)
                        pos++;
                    for (int i = model_count; i > pos; i--) begin
                        model_due[i]  = model_due[i-1];
                        model_recv[i] = model_recv[i-1];
                        model_hand[i] = model_hand[i-1];
                    end
                    model_due[pos]  = due;
                    model_recv[pos] = who;
                    model_hand[pos] = hnd;
                    model_count++;
                    res.status = ST_SCHEDULED;
                end
                res.last = 1'b1;
                awaited_results.push_back(res);
            end
            MODE_TICK: begin
                fire_n = 0;
                while (fire_n < model_count && fire_n < MAX_FIRE && model_due[fire_n] <= at)
                    fire_n++;
                if (fire_n == 0) begin
                    res.status = ST_NOTHING;
                    res.last   = 1'b1;
                    awaited_results.push_back(res);
                end else begin
                    for (int i = 0; i < fire_n; i++) begin
                        res.status = ST_FIRED;
                        res.recv   = model_recv[i];
                        res.hand   = model_hand[i];
                        res.last   = (i == fire_n - 1);
                        awaited_results.push_back(res);
                    end
                    for (int i = fire_n; i < model_count; i++) begin
                        model_due[i-fire_n]  = model_due[i];
                        model_recv[i-fire_n] = model_recv[i];
                        model_hand[i-fire_n] = model_hand[i];
                    end
                    model_count -= fire_n;
                end
            end
            MODE_CANCEL: begin
                kept = 0;
                for (int i = 0; i < model_count; i++) begin
                    if (model_recv[i] != who) begin
                        model_due[kept]  = model_due[i];
                        model_recv[kept] = model_recv[i];
                        model_hand[kept] = model_hand[i];
                        kept++;
                    end
                end
                gone        = model_count - kept;
                model_count = kept;
                res.status  = ST_CANCELLED;
                res.removed = (gone > int'(RM_MAX)) ? RM_MAX : RM_W'(gone);
                res.last    = 1'b1;
                awaited_results.push_back(res);
            end
            default: ;
        endcase
    endtask

    task automatic queue_request(input logic [1:0] op, input logic [TIME_W-1:0] at,
                                 input logic [ID_W-1:0] who, input logic [ID_W-1:0] hnd,
                                 input logic [TIME_W-1:0] dly);
        timer_request_t req;
        req.mode = op;
        req.now  = at;
        req.recv = who;
        req.hand = hnd;
        req.dly  = dly;
        queued_requests.push_back(req);
    endtask

    // Small receiver pool so cancels hit, with full-range ids now and then.
    function automatic logic [ID_W-1:0] pick_receiver();
        if ($urandom_range(0, 4) == 0)
            return ID_W'($urandom);
        return ID_W'($urandom_range(0, 5));
    endfunction

    function automatic logic [TIME_W-1:0] pick_delay();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        if (roll < 20)
            return $urandom;
        if (roll < 25)
            return TIME_MAX - $urandom_range(0, 255);
        return $urandom_range(0, 'h40000);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    // Request driver: hold a stalled beat, otherwise idle or present the next one.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || request_taken) begin
            request_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (queued_requests.size() > 0) begin
                next_request = queued_requests.pop_front();
                in_valid    <= 1'b1;
                mode        <= next_request.mode;
                now_time    <= next_request.now;
                receiver_id <= next_request.recv;
                handler_id  <= next_request.hand;
                delay       <= next_request.dly;
                send_gap     = draw_idle(send_calm);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            advance_timer_model(mode, now_time, receiver_id, handler_id, delay);
            accepted_requests++;
            request_taken = 1'b1;
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
            stall_left = draw_idle(stall_calm);
        end
    end

    always @(posedge clk) begin : watch_results
        queue_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result beat: status 0x%0h", status);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("status", want.status, status);
                check_field("fired_receiver", want.recv, fired_receiver);
                check_field("fired_handler", want.hand, fired_handler);
                check_field("removed_count", want.removed, removed_count);
                check_field("last", want.last, last);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timed_event_queue_unit_tb: FAIL");
            $finish;
        end
    end

    initial begin
        logic [TIME_W-1:0] clock_base;
        logic [1:0]        noise_mode;
        int                random_items;
        int                roll;
        int                burst;

        // empty queue, unused mode, saturation and equal due times
        queue_request(MODE_TICK, '0, '0, '0, '0);
        queue_request(MODE_CANCEL, '0, '0, '0, '0);
        queue_request(MODE_UNUSED, TIME_MAX, '1, '1, TIME_MAX);
        queue_request(MODE_SCHEDULE, TIME_MAX, '1, '1, TIME_MAX);
        queue_request(MODE_SCHEDULE, '0, '0, '0, '0);
        queue_request(MODE_SCHEDULE, 32'd10, 16'd1, 16'd1, 32'd5);
        queue_request(MODE_SCHEDULE, 32'd5, 16'd2, 16'd2, 32'd10);
        queue_request(MODE_SCHEDULE, '0, 16'd3, 16'd3, TIME_MAX);
        queue_request(MODE_TICK, 32'd14, '0, '0, '0);
        queue_request(MODE_TICK, 32'd15, '0, '0, '0);
        queue_request(MODE_CANCEL, '0, '1, '0, '0);
        // fill to capacity in pairs of equal due times, overflow, then flush all
        for (int i = 0; i < CAPACITY - 1; i++)
            queue_request(MODE_SCHEDULE, 32'd100, (i % 2) ? 16'd6 : 16'd5, ID_W'(i + 1),
                          TIME_W'((i / 2) * 3));
        queue_request(MODE_SCHEDULE, 32'd100, 16'd7, 16'd7, '0);
        queue_request(MODE_TICK, TIME_MAX, '0, '0, '0);

        clock_base   = $urandom_range(0, 'h100000);
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
                // schedule burst, then let time run forward and fire
                burst = $urandom_range(1, 20);
                repeat (burst)
                    queue_request(MODE_SCHEDULE, clock_base + $urandom_range(0, 255),
                                  pick_receiver(), ID_W'($urandom), pick_delay());
                random_items += burst;
                burst = $urandom_range(1, 4);
                repeat (burst) begin
                    clock_base += $urandom_range(0, 'h30000);
                    queue_request(MODE_TICK, clock_base, ID_W'($urandom), ID_W'($urandom),
                                  $urandom);
                end
                random_items += burst;
                if ($urandom_range(0, 2) == 0) begin
                    queue_request(MODE_CANCEL, clock_base, pick_receiver(), ID_W'($urandom),
                                  $urandom);
                    random_items++;
                end
            end else if (roll < 8) begin
                queue_request(MODE_CANCEL, clock_base, pick_receiver(), ID_W'($urandom),
                              $urandom);
                random_items++;
            end else if (roll == 8) begin
                if ($urandom_range(0, 1) == 0) begin
                    queue_request(MODE_TICK, TIME_MAX, ID_W'($urandom), ID_W'($urandom),
                                  $urandom);
                end else begin
                    clock_base = $urandom;
                    queue_request(MODE_TICK, clock_base, ID_W'($urandom), ID_W'($urandom),
                                  $urandom);
                end
                random_items++;
            end else begin
                noise_mode = 2'($urandom_range(0, 3));
                queue_request(noise_mode, $urandom, ID_W'($urandom), ID_W'($urandom),
                              $urandom);
                if (noise_mode != MODE_UNUSED)
                    random_items++;
            end
        end
        total_requests = queued_requests.size();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_requests < total_requests || awaited_results.size() > 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("timed_event_queue_unit_tb: PASS");
        else
            $display("timed_event_queue_unit_tb: FAIL");
        $finish;
    end

endmodule
